// ===== rtl/uvs_pkg.sv =====
// Shared types, constants and helpers for the UV sphere vertex generator.
// No dependencies.
`default_nettype none
package uvs_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned AtanEntries     = 24;
  localparam int unsigned DivStages       = 6;
  localparam int unsigned DivBits         = 4;
  localparam logic signed [31:0] CordicStart = 32'sd652032874;
  localparam int PosLimit = 65535;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_XSEG   = 2'd1,
    REG_YSEG   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  col;
    logic [7:0]  row;
    logic [16:0] u;
    logic [16:0] v;
    logic [1:0]  qlon;
    logic [1:0]  qlat;
  } pay_t;

  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] t;
    case (idx)
      0:  t = 32'h2000_0000;
      1:  t = 32'h12E4_051E;
      2:  t = 32'h09FB_385B;
      3:  t = 32'h0511_11D4;
      4:  t = 32'h028B_0D43;
      5:  t = 32'h0145_D7E1;
      6:  t = 32'h00A2_F61E;
      7:  t = 32'h0051_7C55;
      8:  t = 32'h0028_BE53;
      9:  t = 32'h0014_5F2F;
      10: t = 32'h000A_2F98;
      11: t = 32'h0005_17CC;
      12: t = 32'h0002_8BE6;
      13: t = 32'h0001_45F3;
      14: t = 32'h0000_A2FA;
      15: t = 32'h0000_517D;
      16: t = 32'h0000_28BE;
      17: t = 32'h0000_145F;
      18: t = 32'h0000_0A30;
      19: t = 32'h0000_0518;
      20: t = 32'h0000_028C;
      21: t = 32'h0000_0146;
      22: t = 32'h0000_00A3;
      23: t = 32'h0000_0051;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

  // four restoring division steps: {remainder, quotient bits}
  function automatic logic [11:0] div_step4(input logic [7:0] rem, input logic [3:0] bits,
                                            input logic [7:0] d);
    logic [8:0] r;
    logic [3:0] q;
    r = {1'b0, rem};
    for (int i = 3; i >= 0; i--) begin
      r = {r[7:0], bits[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end else begin
        q[i] = 1'b0;
      end
    end
    return {r[7:0], q};
  endfunction

  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    p = (p + 64'sd536870912) >>> 30;
    return p[31:0];
  endfunction

  function automatic logic [16:0] scale_pos(input logic [15:0] rad,
                                            input logic signed [31:0] t);
    logic signed [48:0] m;
    m = $signed({1'b0, rad}) * t;
    m = (m + 49'sd536870912) >>> 30;
    if (m > 49'sd65535) m = 49'sd65535;
    if (m < -49'sd65535) m = -49'sd65535;
    return m[16:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/uv_sphere_vertex_generator_core.sv =====
// UV sphere vertex generator: one grid point accepted every cycle (busy stays low);
// the receiver cannot stall, so each word leaves on valid_o for exactly one cycle.
// Stages: clamp, six radix-16 divider stages, quadrant fold, one CORDIC stage
// per iteration, quadrant map, two multiply stages. Depends on uvs_pkg.
// Async active-low reset clears the valid pipeline, loads radius 256, 16x16.
`default_nettype none
module uv_sphere_vertex_generator_core
  import uvs_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = CordicStagesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [7:0]        grid_col_i,
  input  wire logic [7:0]        grid_row_i,
  output logic                   valid_o,
  output logic signed [16:0]     pos_x_o,
  output logic signed [16:0]     pos_y_o,
  output logic signed [16:0]     pos_z_o,
  output logic [16:0]            tex_u_o,
  output logic [16:0]            tex_v_o,
  output logic                   has_cell_o,
  output logic [15:0]            tri_a0_o,
  output logic [15:0]            tri_a1_o,
  output logic [15:0]            tri_a2_o,
  output logic [15:0]            tri_b0_o,
  output logic [15:0]            tri_b1_o,
  output logic [15:0]            tri_b2_o
);

  localparam int unsigned NC  = CORDIC_STAGES;
  localparam int unsigned NV  = NC + 11;

  // configuration
  logic [15:0] radius_q;
  logic [7:0]  xseg_q, yseg_q, xs, ys;
  logic        wr_en;
  reg_idx_e    widx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;
  assign widx   = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      xseg_q   <= 8'd16;
      yseg_q   <= 8'd16;
    end else if (wr_en) begin
      case (widx)
        REG_RADIUS: radius_q <= pwdata[15:0];
        REG_XSEG:   xseg_q   <= pwdata[7:0];
        REG_YSEG:   yseg_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_RADIUS: prdata = {16'h0, radius_q};
      REG_XSEG:   prdata = {24'h0, xseg_q};
      REG_YSEG:   prdata = {24'h0, yseg_q};
      default:    prdata = 32'h0;
    endcase
  end

  assign xs = (xseg_q == 8'd0) ? 8'd1 : xseg_q;
  assign ys = (yseg_q == 8'd0) ? 8'd1 : yseg_q;

  // valid pipeline
  logic [NV-1:0] vld_q, vld_d;
  assign vld_d = {vld_q[NV-2:0], start & ~busy};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= vld_d;
  end

  // clamp and divide
  logic [7:0]  col_q [DivStages+1];
  logic [7:0]  row_q [DivStages+1];
  logic [7:0]  remu_q [DivStages+1];
  logic [7:0]  remv_q [DivStages+1];
  logic [23:0] quou_q [DivStages+1];
  logic [23:0] quov_q [DivStages+1];

  always_ff @(posedge clk_i) begin
    col_q[0]  <= (grid_col_i > xs) ? xs : grid_col_i;
    row_q[0]  <= (grid_row_i > ys) ? ys : grid_row_i;
    remu_q[0] <= '0;
    remv_q[0] <= '0;
    quou_q[0] <= '0;
    quov_q[0] <= '0;
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    logic [23:0] du, dv;
    logic [11:0] su, sv;
    assign du = {col_q[k], 16'h0};
    assign dv = {row_q[k], 16'h0};
    assign su = div_step4(remu_q[k], du[23-DivBits*k -: DivBits], xs);
    assign sv = div_step4(remv_q[k], dv[23-DivBits*k -: DivBits], ys);
    always_ff @(posedge clk_i) begin
      col_q[k+1]  <= col_q[k];
      row_q[k+1]  <= row_q[k];
      remu_q[k+1] <= su[11:4];
      remv_q[k+1] <= sv[11:4];
      quou_q[k+1] <= {quou_q[k][19:0], su[3:0]};
      quov_q[k+1] <= {quov_q[k][19:0], sv[3:0]};
    end
  end

  // quadrant fold and CORDIC
  pay_t               pay_q [NC+1];
  logic signed [31:0] xl_q [NC+1], yl_q [NC+1], zl_q [NC+1];
  logic signed [31:0] xt_q [NC+1], yt_q [NC+1], zt_q [NC+1];
  logic [31:0]        ph_lon, ph_lat, pl, pt;
  logic [16:0]        u_w, v_w;

  assign u_w    = quou_q[DivStages][16:0];
  assign v_w    = quov_q[DivStages][16:0];
  assign ph_lon = {u_w[15:0], 16'h0};
  assign ph_lat = {v_w, 15'h0};
  assign pl     = ph_lon + 32'h2000_0000;
  assign pt     = ph_lat + 32'h2000_0000;

  always_ff @(posedge clk_i) begin
    pay_q[0] <= '{col: col_q[DivStages], row: row_q[DivStages], u: u_w, v: v_w,
                  qlon: pl[31:30], qlat: pt[31:30]};
    xl_q[0] <= CordicStart;
    yl_q[0] <= '0;
    zl_q[0] <= $signed(ph_lon - {pl[31:30], 30'h0});
    xt_q[0] <= CordicStart;
    yt_q[0] <= '0;
    zt_q[0] <= $signed(ph_lat - {pt[31:30], 30'h0});
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    localparam logic signed [31:0] At = $signed(atan_turn(i));
    always_ff @(posedge clk_i) begin
      pay_q[i+1] <= pay_q[i];
      if (zl_q[i] >= 0) begin
        xl_q[i+1] <= xl_q[i] - (yl_q[i] >>> i);
        yl_q[i+1] <= yl_q[i] + (xl_q[i] >>> i);
        zl_q[i+1] <= zl_q[i] - At;
      end else begin
        xl_q[i+1] <= xl_q[i] + (yl_q[i] >>> i);
        yl_q[i+1] <= yl_q[i] - (xl_q[i] >>> i);
        zl_q[i+1] <= zl_q[i] + At;
      end
      if (zt_q[i] >= 0) begin
        xt_q[i+1] <= xt_q[i] - (yt_q[i] >>> i);
        yt_q[i+1] <= yt_q[i] + (xt_q[i] >>> i);
        zt_q[i+1] <= zt_q[i] - At;
      end else begin
        xt_q[i+1] <= xt_q[i] + (yt_q[i] >>> i);
        yt_q[i+1] <= yt_q[i] - (xt_q[i] >>> i);
        zt_q[i+1] <= zt_q[i] + At;
      end
    end
  end

  // quadrant map
  pay_t               mp_pay_q;
  logic signed [31:0] clon_q, slon_q, clat_q, slat_q;
  logic signed [31:0] clon_d, slon_d, clat_d, slat_d;

  always_comb begin
    case (pay_q[NC].qlon)
      2'd0:    begin clon_d = xl_q[NC];  slon_d = yl_q[NC];  end
      2'd1:    begin clon_d = -yl_q[NC]; slon_d = xl_q[NC];  end
      2'd2:    begin clon_d = -xl_q[NC]; slon_d = -yl_q[NC]; end
      default: begin clon_d = yl_q[NC];  slon_d = -xl_q[NC]; end
    endcase
    case (pay_q[NC].qlat)
      2'd0:    begin clat_d = xt_q[NC];  slat_d = yt_q[NC];  end
      2'd1:    begin clat_d = -yt_q[NC]; slat_d = xt_q[NC];  end
      2'd2:    begin clat_d = -xt_q[NC]; slat_d = -yt_q[NC]; end
      default: begin clat_d = yt_q[NC];  slat_d = -xt_q[NC]; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mp_pay_q <= pay_q[NC];
    clon_q   <= clon_d;
    slon_q   <= slon_d;
    clat_q   <= clat_d;
    slat_q   <= slat_d;
  end

  // first products
  pay_t               m1_pay_q;
  logic signed [31:0] tx_q, tz_q, cy_q;
  always_ff @(posedge clk_i) begin
    m1_pay_q <= mp_pay_q;
    tx_q     <= mul_q30(clon_q, slat_q);
    tz_q     <= mul_q30(slon_q, slat_q);
    cy_q     <= clat_q;
  end

  // radius scaling and indices
  logic [8:0]  stride;
  logic [16:0] here, below;
  logic        cell_ok;
  assign stride  = {1'b0, xs} + 9'd1;
  assign here    = {9'h0, m1_pay_q.row} * {8'h0, stride} + {9'h0, m1_pay_q.col};
  assign below   = here + {8'h0, stride};
  assign cell_ok = (m1_pay_q.col < xs) && (m1_pay_q.row < ys);

  always_ff @(posedge clk_i) begin
    pos_x_o    <= scale_pos(radius_q, tx_q);
    pos_y_o    <= scale_pos(radius_q, cy_q);
    pos_z_o    <= scale_pos(radius_q, tz_q);
    tex_u_o    <= m1_pay_q.u;
    tex_v_o    <= m1_pay_q.v;
    has_cell_o <= cell_ok;
    tri_a0_o   <= cell_ok ? below[15:0] : 16'h0;
    tri_a1_o   <= cell_ok ? here[15:0] : 16'h0;
    tri_a2_o   <= cell_ok ? here[15:0] + 16'd1 : 16'h0;
    tri_b0_o   <= cell_ok ? below[15:0] : 16'h0;
    tri_b1_o   <= cell_ok ? here[15:0] + 16'd1 : 16'h0;
    tri_b2_o   <= cell_ok ? below[15:0] + 16'd1 : 16'h0;
  end

  assign valid_o = vld_q[NV-1];

endmodule
`default_nettype wire

// ===== rtl/uvs_checker.sv =====
// Port-level checks for the UV sphere vertex generator, bound to the top level.
// Depends on uvs_pkg.
`default_nettype none
module uvs_checker
  import uvs_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        busy,
  input wire logic        valid_o,
  input wire logic [16:0] tex_u_o,
  input wire logic [16:0] tex_v_o,
  input wire logic        has_cell_o,
  input wire logic [15:0] tri_a0_o,
  input wire logic [15:0] tri_a1_o,
  input wire logic [15:0] tri_a2_o,
  input wire logic [15:0] tri_b0_o,
  input wire logic [15:0] tri_b1_o,
  input wire logic [15:0] tri_b2_o
);

  a_shared_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && has_cell_o |-> tri_a0_o == tri_b0_o && tri_a2_o == tri_b1_o
                              && tri_a2_o == tri_a1_o + 16'd1)
    else $error("cell triangles do not share the diagonal");

  a_no_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !has_cell_o |-> tri_a0_o == 16'h0 && tri_a1_o == 16'h0 && tri_a2_o == 16'h0
                               && tri_b0_o == 16'h0 && tri_b1_o == 16'h0 && tri_b2_o == 16'h0)
    else $error("indices given without a cell");

  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> tex_u_o <= 17'h10000 && tex_v_o <= 17'h10000)
    else $error("texture coordinate above one");

  a_cell_tex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && has_cell_o |-> tex_u_o != 17'h10000 && tex_v_o != 17'h10000)
    else $error("cell reported on the last row or column");

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised on a fully pipelined block");

endmodule

bind uv_sphere_vertex_generator_core uvs_checker u_uvs_checker (.*);
`default_nettype wire

// ===== bench/tb_uv_sphere_vertex_generator_core.sv =====
// Self-checking bench for the UV sphere vertex generator core.
// Holds its own CORDIC/divider predictor and drives the APB port and command port.
// Depends on uvs_pkg and rtl/uv_sphere_vertex_generator_core.sv.
`default_nettype none
module tb_uv_sphere_vertex_generator_core
  import uvs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Stages  = 16;
  localparam int unsigned Latency = Stages + 11;

  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               has_cell;
    logic [5:0][15:0]   tri_idx;
  } vertex_t;

  typedef struct {
    logic [7:0]  col;
    logic [7:0]  row;
    bit          typed;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic        has_cell;
  } grid_row_t;

  localparam logic [31:0] AtanTurn[0:23] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [7:0] grid_col_i = '0, grid_row_i = '0;
  logic valid_o;
  logic signed [16:0] pos_x_o, pos_y_o, pos_z_o;
  logic [16:0] tex_u_o, tex_v_o;
  logic has_cell_o;
  logic [15:0] tri_a0_o, tri_a1_o, tri_a2_o, tri_b0_o, tri_b1_o, tri_b2_o;

  logic [15:0] radius_q;
  logic [7:0]  xseg_q, yseg_q;
  vertex_t     pending_vertices[$];
  int unsigned accepted_words = 0;
  int unsigned mismatches = 0;
  int          idle_pct = 0;

  uv_sphere_vertex_generator_core #(.CORDIC_STAGES(Stages)) u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .grid_col_i, .grid_row_i, .valid_o, .pos_x_o, .pos_y_o, .pos_z_o,
    .tex_u_o, .tex_v_o, .has_cell_o, .tri_a0_o, .tri_a1_o, .tri_a2_o, .tri_b0_o,
    .tri_b1_o, .tri_b2_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2ms;
    $display("[uv_sphere_vertex_generator_core] ERROR");
    $finish;
  end

  function automatic longint round_q30(input longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [16:0] clip_pos(input longint v);
    if (v > 65535) v = 65535;
    if (v < -65535) v = -65535;
    return v[16:0];
  endfunction

  task automatic rotate_phase(input logic [31:0] phase, output longint c, output longint s);
    logic [1:0]  q;
    logic [31:0] r;
    longint x, y, z, dx, dy;
    q = 2'((phase + 32'h2000_0000) >> 30);
    r = phase - {q, 30'b0};
    z = longint'($signed(r));
    x = 652032874;
    y = 0;
    for (int i = 0; i < Stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(AtanTurn[i]);
      end else begin
        x += dx; y -= dy; z += longint'(AtanTurn[i]);
      end
    end
    case (q)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic vertex_predict(input logic [7:0] col_in, input logic [7:0] row_in,
                                output vertex_t vx);
    int unsigned xs, ys, col, row, u, v, here, below;
    longint clon, slon, clat, slat, rad;
    xs  = (xseg_q == 0) ? 1 : xseg_q;
    ys  = (yseg_q == 0) ? 1 : yseg_q;
    col = (col_in > xs) ? xs : col_in;
    row = (row_in > ys) ? ys : row_in;
    u   = (col << 16) / xs;
    v   = (row << 16) / ys;
    rotate_phase(u << 16, clon, slon);
    rotate_phase(v << 15, clat, slat);
    rad = radius_q;
    vx.pos_x    = clip_pos(round_q30(rad * round_q30(clon * slat)));
    vx.pos_y    = clip_pos(round_q30(rad * clat));
    vx.pos_z    = clip_pos(round_q30(rad * round_q30(slon * slat)));
    vx.tex_u    = u[16:0];
    vx.tex_v    = v[16:0];
    vx.has_cell = (col < xs) && (row < ys);
    vx.tri_idx  = '0;
    if (vx.has_cell) begin
      here  = row * (xs + 1) + col;
      below = here + xs + 1;
      vx.tri_idx[0] = below[15:0];
      vx.tri_idx[1] = here[15:0];
      vx.tri_idx[2] = 16'(here + 1);
      vx.tri_idx[3] = below[15:0];
      vx.tri_idx[4] = 16'(here + 1);
      vx.tri_idx[5] = 16'(below + 1);
    end
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_RADIUS: radius_q = data[15:0];
      REG_XSEG:   xseg_q = data[7:0];
      REG_YSEG:   yseg_q = data[7:0];
      default: ;
    endcase
  endtask

  // unmapped address: write must be dropped
  task automatic apb_write_hole(input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 4'd12; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_word(input grid_row_t w);
    vertex_t vx;
    int unsigned target;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    grid_col_i <= w.col;
    grid_row_i <= w.row;
    target = accepted_words + 1;
    @(posedge clk_i);
    wait (accepted_words == target);
    vertex_predict(w.col, w.row, vx);
    if (w.typed) begin
      vx.tex_u = w.tex_u;
      vx.tex_v = w.tex_v;
      vx.has_cell = w.has_cell;
    end
    pending_vertices = {pending_vertices, vx};
  endtask

  task automatic drain();
    start <= 1'b0;
    wait (pending_vertices.size() == 0);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [16:0] exp_v,
                             input logic [16:0] act_v);
    if (exp_v !== act_v) begin
      if (mismatches < 10)
        $display("%t mismatch %s: expected %h, got %h", $realtime, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni) begin
      if (start && !busy) accepted_words++;
      if (valid_o) begin
        if (pending_vertices.size() == 0) begin
          if (mismatches < 10) $display("%t unexpected word", $realtime);
          mismatches++;
        end else begin
          e = pending_vertices.pop_front();
          check_field("pos_x", e.pos_x, pos_x_o);
          check_field("pos_y", e.pos_y, pos_y_o);
          check_field("pos_z", e.pos_z, pos_z_o);
          check_field("tex_u", e.tex_u, tex_u_o);
          check_field("tex_v", e.tex_v, tex_v_o);
          check_field("has_cell", 17'(e.has_cell), 17'(has_cell_o));
          check_field("tri_a0", 17'(e.tri_idx[0]), 17'(tri_a0_o));
          check_field("tri_a1", 17'(e.tri_idx[1]), 17'(tri_a1_o));
          check_field("tri_a2", 17'(e.tri_idx[2]), 17'(tri_a2_o));
          check_field("tri_b0", 17'(e.tri_idx[3]), 17'(tri_b0_o));
          check_field("tri_b1", 17'(e.tri_idx[4]), 17'(tri_b1_o));
          check_field("tri_b2", 17'(e.tri_idx[5]), 17'(tri_b2_o));
        end
      end
    end
  end

  initial begin
    grid_row_t directed[] = '{
      '{8'd0,   8'd0,   1'b1, 17'd0,     17'd0,     1'b1},
      '{8'd8,   8'd8,   1'b1, 17'd32768, 17'd32768, 1'b1},
      '{8'd4,   8'd12,  1'b1, 17'd16384, 17'd49152, 1'b1},
      '{8'd15,  8'd15,  1'b0, 17'd0,     17'd0,     1'b0},
      '{8'd16,  8'd16,  1'b1, 17'd65536, 17'd65536, 1'b0},
      '{8'd255, 8'd255, 1'b1, 17'd65536, 17'd65536, 1'b0},
      '{8'd255, 8'd0,   1'b1, 17'd65536, 17'd0,     1'b0},
      '{8'd0,   8'd255, 1'b1, 17'd0,     17'd65536, 1'b0},
      '{8'd15,  8'd16,  1'b1, 17'd61440, 17'd65536, 1'b0},
      '{8'd16,  8'd3,   1'b1, 17'd65536, 17'd12288, 1'b0},
      '{8'd170, 8'd85,  1'b0, 17'd0,     17'd0,     1'b0},
      '{8'd85,  8'd170, 1'b0, 17'd0,     17'd0,     1'b0},
      '{8'd2,   8'd1,   1'b0, 17'd0,     17'd0,     1'b0},
      '{8'd13,  8'd7,   1'b0, 17'd0,     17'd0,     1'b0}};
    logic [31:0] cfg[][3] = '{
      '{32'h0000_FFFF, 32'h0000_00FF, 32'h0000_00FF},
      '{32'h0000_0000, 32'h0000_0001, 32'h0000_0001},
      '{32'hFFFF_0100, 32'hFFFF_FF00, 32'h1234_5600},
      '{32'h0000_0100, 32'h0000_0007, 32'h0000_0003},
      '{32'h0000_FFFF, 32'h0000_0002, 32'h0000_00FE},
      '{32'h0000_0C80, 32'h0000_0040, 32'h0000_0020},
      '{32'h0000_8000, 32'h0000_0011, 32'h0000_0005},
      '{32'h0000_0100, 32'h0000_0010, 32'h0000_0010}};
    int phase_idle[4] = '{0, 64, 0, 18};
    grid_row_t w;
    int unsigned xs, ys;

    radius_q = 16'd256;
    xseg_q   = 8'd16;
    yseg_q   = 8'd16;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_word(directed[i]);
    drain();
    apb_write_hole(32'hDEAD_BEEF);
    send_word('{8'd8, 8'd8, 1'b1, 17'd32768, 17'd32768, 1'b1});

    for (int p = 0; p < 10; p++) begin
      drain();
      if (p < cfg.size()) begin
        apb_write(REG_RADIUS, cfg[p][0]);
        apb_write(REG_XSEG, cfg[p][1]);
        apb_write(REG_YSEG, cfg[p][2]);
      end else begin
        apb_write(REG_RADIUS, $urandom);
        apb_write(REG_XSEG, $urandom_range(255));
        apb_write(REG_YSEG, $urandom_range(255));
      end
      idle_pct = phase_idle[p % 4];
      xs = (xseg_q == 0) ? 1 : xseg_q;
      ys = (yseg_q == 0) ? 1 : yseg_q;
      for (int n = 0; n < 100; n++) begin
        w.typed = 1'b0;
        if ($urandom_range(9) < 8) begin
          w.col = 8'($urandom_range(xs < 255 ? xs + 1 : 255));
          w.row = 8'($urandom_range(ys < 255 ? ys + 1 : 255));
        end else begin
          w.col = 8'($urandom);
          w.row = 8'($urandom);
        end
        send_word(w);
      end
    end

    drain();
    if (mismatches == 0)
      $display("[uv_sphere_vertex_generator_core] OK");
    else
      $display("[uv_sphere_vertex_generator_core] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
